FILE: hdl/sync_word_bit_correlator_top_assert.svh
// Assertion macros for the sync word bit correlator.
`ifndef SYNC_WORD_BIT_CORRELATOR_TOP_ASSERT_SVH
`define SYNC_WORD_BIT_CORRELATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define SWBC_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swbc assertion failed");

// next-cycle implication
`define SWBC_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swbc assertion failed");

`endif

FILE: hdl/swbc_pkg.sv
// Package: types, constants and helper functions of the sync word bit correlator.
package swbc_pkg;

   localparam int DATA_W          = 8;
   localparam int POS_W           = 16;
   localparam int WIN_W           = 64;
   localparam int WIN_BYTES       = WIN_W / DATA_W;
   localparam int LEN_W           = 7;
   localparam int IDX_W           = $clog2(DATA_W);
   localparam int CNT_W           = $clog2(DATA_W + 1);
   localparam int DIST_W          = 7;
   localparam int MAX_FRAME_BYTES = 4096;
   localparam int BIT_LIMIT       = MAX_FRAME_BYTES * DATA_W;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W       = 1;

   localparam logic [POS_W-1:0]     BIT_LIMIT_POS    = POS_W'(BIT_LIMIT);
   localparam logic [DIST_W-1:0]    DIST_NONE        = '1;
   localparam logic [LEN_W-1:0]     LEN_RESET        = LEN_W'(WIN_W);
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_PATTERN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_LENGTH  = 1'b1;

   // one queued item, already classified by the front end
   typedef struct packed {
      logic [WIN_W-1:0]  window;     // window before the first bit of the item
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  base;       // bit position of the first bit
      logic [DATA_W-1:0] pos_valid;  // positions that get scored
      logic              first;      // first item of a frame
      logic              last;
   } swbc_item_type;

   typedef struct packed {
      logic [DIST_W-1:0] score;
      logic [IDX_W-1:0]  idx;
      logic              inv;
   } swbc_cand_type;

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] n;
      if (raw == '0) begin
         n = LEN_W'(1);
      end else if (raw > LEN_W'(WIN_W)) begin
         n = LEN_W'(WIN_W);
      end else begin
         n = raw;
      end
      return n;
   endfunction

   function automatic logic [WIN_W-1:0] len_mask(input logic [LEN_W-1:0] n);
      logic [WIN_W-1:0] m;
      if (n >= LEN_W'(WIN_W)) begin
         m = '1;
      end else begin
         m = (WIN_W'(1) << n) - WIN_W'(1);
      end
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] popcount8(input logic [DATA_W-1:0] v);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < DATA_W; i++) begin
         c = c + CNT_W'(v[i]);
      end
      return c;
   endfunction

endpackage

FILE: hdl/swbc_front.sv
// Front end: accepts items, tracks window and bit position, classifies positions.
module swbc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swbc_pkg::DATA_W-1:0]   req_data_byte,
   input  logic                          req_last_byte,
   input  logic [swbc_pkg::LEN_W-1:0]    len,
   input  logic [swbc_pkg::WIN_W-1:0]    mask,
   input  logic                          q_full,
   output logic                          q_push,
   output swbc_pkg::swbc_item_type       q_item
);

   logic [swbc_pkg::WIN_W-1:0] window_ff, window_in;
   logic [swbc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       accept;
   logic [swbc_pkg::DATA_W-1:0] pos_valid;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      for (int j = 0; j < swbc_pkg::DATA_W; j++) begin
         pos_valid[j] = (pos_ff < swbc_pkg::BIT_LIMIT_POS) &&
            (({1'b0, pos_ff} + (swbc_pkg::POS_W + 1)'(j)) >=
             (swbc_pkg::POS_W + 1)'(len));
      end
   end

   always_comb begin
      q_item.window    = window_ff;
      q_item.data      = req_data_byte;
      q_item.base      = pos_ff;
      q_item.pos_valid = pos_valid;
      q_item.first     = (pos_ff == '0);
      q_item.last      = req_last_byte;
   end

   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      if (accept) begin
         if (req_last_byte) begin
            window_in = '0;
            pos_in    = '0;
         end else begin
            window_in = {window_ff[swbc_pkg::WIN_W-swbc_pkg::DATA_W-1:0], req_data_byte}
                        & mask;
            // position saturates at the frame limit
            if (pos_ff < swbc_pkg::BIT_LIMIT_POS) begin
               pos_in = pos_ff + swbc_pkg::POS_W'(swbc_pkg::DATA_W);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

FILE: hdl/swbc_queue.sv
// Short item queue between the front end and the back end.
module swbc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  swbc_pkg::swbc_item_type  push_item,
   input  logic                     pop,
   output swbc_pkg::swbc_item_type  head_item,
   output logic                     empty,
   output logic                     full
);

   swbc_pkg::swbc_item_type          entry_ff [swbc_pkg::QUEUE_DEPTH];
   logic [swbc_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [swbc_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [swbc_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == swbc_pkg::QCNT_W'(swbc_pkg::QUEUE_DEPTH));
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + swbc_pkg::QCNT_W'(push) - swbc_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hdl/swbc_back.sv
// Back end: distance pipeline, best-match tracking and the result register.
module swbc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  swbc_pkg::swbc_item_type       head_item,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [swbc_pkg::WIN_W-1:0]    pattern,
   input  logic [swbc_pkg::LEN_W-1:0]    len,
   input  logic [swbc_pkg::WIN_W-1:0]    mask,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [swbc_pkg::POS_W-1:0] rsp_sync_offset,
   output logic                          rsp_inverted
);

   typedef logic [swbc_pkg::DATA_W-1:0][swbc_pkg::WIN_BYTES-1:0][swbc_pkg::CNT_W-1:0]
      cnt_type;

   logic back_en;

   // stage 1: byte-wise popcounts per bit position
   logic                        s1_vld_ff;
   cnt_type                     s1_cnt_ff, s1_cnt_in;
   logic [swbc_pkg::POS_W-1:0]  s1_base_ff;
   logic [swbc_pkg::DATA_W-1:0] s1_pv_ff;
   logic                        s1_first_ff, s1_last_ff;

   // stage 2: per-position candidate
   logic                       s2_vld_ff;
   swbc_pkg::swbc_cand_type    s2_cand_ff [swbc_pkg::DATA_W];
   swbc_pkg::swbc_cand_type    s2_cand_in [swbc_pkg::DATA_W];
   logic [swbc_pkg::POS_W-1:0] s2_base_ff;
   logic                       s2_first_ff, s2_last_ff;

   // stage 3: best candidate of the item
   logic                       s3_vld_ff;
   swbc_pkg::swbc_cand_type    s3_cand_ff, s3_cand_in;
   logic [swbc_pkg::POS_W-1:0] s3_base_ff;
   logic                       s3_first_ff, s3_last_ff;

   // running best of the frame
   logic [swbc_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [swbc_pkg::POS_W-1:0]  best_pos_ff, best_pos_in;
   logic                        best_inv_ff, best_inv_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [swbc_pkg::POS_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic                        rsp_inv_ff, rsp_inv_in;

   function automatic swbc_pkg::swbc_cand_type pick(input swbc_pkg::swbc_cand_type l,
                                                    input swbc_pkg::swbc_cand_type r);
      // earlier candidate wins a tie
      return (r.score < l.score) ? r : l;
   endfunction

   assign back_en = !rsp_valid_ff || !rsp_stall;
   assign q_pop   = back_en && !q_empty;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sync_offset = rsp_offset_ff;
   assign rsp_inverted    = rsp_inv_ff;

   always_comb begin
      logic [swbc_pkg::WIN_W+swbc_pkg::DATA_W-1:0] cat;
      logic [swbc_pkg::WIN_W-1:0] word;
      logic [swbc_pkg::WIN_W-1:0] win;
      logic [swbc_pkg::WIN_W-1:0] diff;
      word = pattern & mask;
      for (int j = 0; j < swbc_pkg::DATA_W; j++) begin
         // window as seen just before bit j of the item is shifted in
         cat  = {head_item.window, head_item.data} >> (swbc_pkg::DATA_W - j);
         win  = cat[swbc_pkg::WIN_W-1:0] & mask;
         diff = (word ^ win) & mask;
         for (int b = 0; b < swbc_pkg::WIN_BYTES; b++) begin
            s1_cnt_in[j][b] = swbc_pkg::popcount8(diff[b*swbc_pkg::DATA_W +:
                                                        swbc_pkg::DATA_W]);
         end
      end
   end

   always_comb begin
      logic [swbc_pkg::DIST_W-1:0] d;
      logic [swbc_pkg::DIST_W-1:0] dc;
      for (int j = 0; j < swbc_pkg::DATA_W; j++) begin
         d = '0;
         for (int b = 0; b < swbc_pkg::WIN_BYTES; b++) begin
            d = d + swbc_pkg::DIST_W'(s1_cnt_ff[j][b]);
         end
         dc = swbc_pkg::DIST_W'(len) - d;
         s2_cand_in[j].idx = swbc_pkg::IDX_W'(j);
         if (!s1_pv_ff[j]) begin
            s2_cand_in[j].score = swbc_pkg::DIST_NONE;
            s2_cand_in[j].inv   = 1'b0;
         end else if (dc < d) begin
            s2_cand_in[j].score = dc;
            s2_cand_in[j].inv   = 1'b1;
         end else begin
            s2_cand_in[j].score = d;
            s2_cand_in[j].inv   = 1'b0;
         end
      end
   end

   always_comb begin
      swbc_pkg::swbc_cand_type l1 [swbc_pkg::DATA_W/2];
      swbc_pkg::swbc_cand_type l2 [swbc_pkg::DATA_W/4];
      for (int i = 0; i < swbc_pkg::DATA_W/2; i++) begin
         l1[i] = pick(s2_cand_ff[2*i], s2_cand_ff[2*i+1]);
      end
      for (int i = 0; i < swbc_pkg::DATA_W/4; i++) begin
         l2[i] = pick(l1[2*i], l1[2*i+1]);
      end
      s3_cand_in = pick(l2[0], l2[1]);
   end

   always_comb begin
      logic [swbc_pkg::DIST_W-1:0] prior_dist;
      logic [swbc_pkg::POS_W-1:0]  prior_pos;
      logic                        prior_inv;
      // a new frame starts from distance equal to the word length
      prior_dist = s3_first_ff ? swbc_pkg::DIST_W'(len) : best_dist_ff;
      prior_pos  = s3_first_ff ? '0 : best_pos_ff;
      prior_inv  = s3_first_ff ? 1'b0 : best_inv_ff;
      if (s3_cand_ff.score < prior_dist) begin
         best_dist_in = s3_cand_ff.score;
         best_pos_in  = s3_base_ff + swbc_pkg::POS_W'(s3_cand_ff.idx);
         best_inv_in  = s3_cand_ff.inv;
      end else begin
         best_dist_in = prior_dist;
         best_pos_in  = prior_pos;
         best_inv_in  = prior_inv;
      end
      rsp_valid_in  = s3_vld_ff && s3_last_ff;
      rsp_offset_in = best_pos_in - swbc_pkg::POS_W'(len);
      rsp_inv_in    = best_inv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         s1_vld_ff    <= !q_empty;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         s1_cnt_ff   <= s1_cnt_in;
         s1_base_ff  <= head_item.base;
         s1_pv_ff    <= head_item.pos_valid;
         s1_first_ff <= head_item.first;
         s1_last_ff  <= head_item.last;
         for (int j = 0; j < swbc_pkg::DATA_W; j++) begin
            s2_cand_ff[j] <= s2_cand_in[j];
         end
         s2_base_ff  <= s1_base_ff;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s3_cand_ff  <= s3_cand_in;
         s3_base_ff  <= s2_base_ff;
         s3_first_ff <= s2_first_ff;
         s3_last_ff  <= s2_last_ff;
         if (s3_vld_ff) begin
            best_dist_ff <= best_dist_in;
            best_pos_ff  <= best_pos_in;
            best_inv_ff  <= best_inv_in;
         end
         if (rsp_valid_in) begin
            rsp_offset_ff <= rsp_offset_in;
            rsp_inv_ff    <= rsp_inv_in;
         end
      end
   end

endmodule

FILE: hdl/sync_word_bit_correlator_top.sv
// Top level of the sync word bit correlator.
//
// Input channel req_: one frame byte per item (req_data_byte, MSB first) and
// req_last_byte marking the final byte of a frame. Result channel rsp_: one
// item per frame, sent for the last byte: rsp_sync_offset (signed bit index
// where the best match starts, -sync_length if no match) and rsp_inverted.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. Config port csr_: index 0 is the 64-bit sync pattern, index 1 the
// sync length (1..64, 0 reads as 1, above 64 as 64). Write only while idle.
// Throughput: one byte per cycle while req_stall is low. The eight positions of
// a byte are scored in parallel in a four-stage back end; the running-best
// compare is the only loop. The last byte passes the queue and stages 1 to 3
// before its result is registered.
// A four-entry queue separates intake from scoring; when rsp_stall holds a
// result, the back end freezes and intake continues until the queue fills.
// Reset: synchronous; pattern 0, length 64, frame state and queue cleared.
`include "sync_word_bit_correlator_top_assert.svh"

module sync_word_bit_correlator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [swbc_pkg::DATA_W-1:0]       req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [swbc_pkg::POS_W-1:0] rsp_sync_offset,
   output logic                              rsp_inverted,
   input  logic                              csr_write,
   input  logic [swbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [swbc_pkg::WIN_W-1:0]        csr_wdata
);

   logic [swbc_pkg::WIN_W-1:0] pattern_ff, pattern_in;
   logic [swbc_pkg::LEN_W-1:0] length_ff, length_in;
   logic [swbc_pkg::LEN_W-1:0] len;
   logic [swbc_pkg::WIN_W-1:0] mask;

   logic                    q_push, q_pop, q_empty, q_full;
   swbc_pkg::swbc_item_type q_push_item, q_head_item;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_write) begin
         case (csr_index)
            swbc_pkg::CSR_SYNC_PATTERN: pattern_in = csr_wdata;
            swbc_pkg::CSR_SYNC_LENGTH:  length_in  = csr_wdata[swbc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= swbc_pkg::LEN_RESET;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   assign len  = swbc_pkg::eff_len(length_ff);
   assign mask = swbc_pkg::len_mask(len);

   swbc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .len           (len),
      .mask          (mask),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_push_item)
   );

   swbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   swbc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (q_head_item),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .pattern         (pattern_ff),
      .len             (len),
      .mask            (mask),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sync_offset (rsp_sync_offset),
      .rsp_inverted    (rsp_inverted)
   );

   // front end never writes into a full queue
   `SWBC_ASSERT_IMP(a_no_push_full, q_push, !q_full)
   // back end drains the queue whenever the result side is not blocked
   `SWBC_ASSERT_IMP(a_drain, !q_empty && !(rsp_valid && rsp_stall), q_pop)
   // offset never falls below minus the longest sync word
   `SWBC_ASSERT_IMP(a_offset_range, rsp_valid, $signed(rsp_sync_offset) >= -16'sd64)

endmodule

FILE: tb/tb_sync_word_bit_correlator_top.sv
// Testbench for the sync word bit correlator: framed byte streams checked by a bit-level model.
module tb_sync_word_bit_correlator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int ITEM_TARGET  = 1300;
   localparam int MAX_WAIT     = 16;
   localparam int DRAIN_CYCLES = 16;
   // covers a sender gap or receiver stall plus pipeline and queue, with a wide margin
   localparam int QUIET_LIMIT  = 2000;

   localparam int DATA_W = swbc_pkg::DATA_W;
   localparam int POS_W  = swbc_pkg::POS_W;
   localparam int WIN_W  = swbc_pkg::WIN_W;
   localparam int LEN_W  = swbc_pkg::LEN_W;
   localparam int IDX_W  = swbc_pkg::CSR_IDX_W;

   typedef struct packed {
      logic [POS_W-1:0] offset;
      logic             inverted;
   } sync_hit_type;

   // running copy of the correlator: registers, frame state and hits owed by the block
   class sync_hunt_board;
      logic [WIN_W-1:0] pattern;
      logic [LEN_W-1:0] len_raw;
      logic [WIN_W-1:0] window;
      int unsigned      bit_pos;
      int unsigned      best_dist;
      int unsigned      best_pos;
      logic             best_inv;
      sync_hit_type     hits_due[$];
      int               errors;

      function new();
         pattern = '0;
         len_raw = LEN_W'(WIN_W);
         errors  = 0;
         restart();
      endfunction

      function int unsigned span();
         if (len_raw == '0) return 1;
         if (len_raw > LEN_W'(WIN_W)) return WIN_W;
         return len_raw;
      endfunction

      function logic [WIN_W-1:0] width_mask(input int unsigned n);
         if (n >= WIN_W) return '1;
         return (WIN_W'(1) << n) - WIN_W'(1);
      endfunction

      function void restart();
         window    = '0;
         bit_pos   = 0;
         best_dist = span();
         best_pos  = 0;
         best_inv  = 1'b0;
      endfunction

      function void write_reg(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
         if (idx == swbc_pkg::CSR_SYNC_PATTERN) begin
            pattern = value;
         end else if (idx == swbc_pkg::CSR_SYNC_LENGTH) begin
            len_raw = value[LEN_W-1:0];
            if (bit_pos == 0) best_dist = span();
         end
      endfunction

      function void take_byte(input logic [DATA_W-1:0] data, input logic last);
         int               j;
         int unsigned      n;
         int unsigned      d;
         int unsigned      dc;
         logic [WIN_W-1:0] mask;
         logic [WIN_W-1:0] word;
         sync_hit_type     hit;
         for (j = DATA_W - 1; j >= 0; j--) begin
            n    = span();
            mask = width_mask(n);
            word = pattern & mask;
            // score before the bit goes in; plain word wins ties with the complement
            if (bit_pos < swbc_pkg::BIT_LIMIT && bit_pos >= n) begin
               d  = $countones((word ^ window) & mask);
               dc = n - d;
               if (d < best_dist) begin
                  best_dist = d;
                  best_pos  = bit_pos;
                  best_inv  = 1'b0;
               end
               if (dc < best_dist) begin
                  best_dist = dc;
                  best_pos  = bit_pos;
                  best_inv  = 1'b1;
               end
            end
            window = ((window << 1) | WIN_W'(data[j])) & mask;
            if (bit_pos < swbc_pkg::BIT_LIMIT) bit_pos++;
         end
         if (last) begin
            hit.offset   = POS_W'(best_pos - span());
            hit.inverted = best_inv;
            hits_due.push_back(hit);
            restart();
         end
      endfunction

      function void check_hit(input logic [POS_W-1:0] offset, input logic inverted);
         sync_hit_type due;
         if (hits_due.size() == 0) begin
            $error("unexpected result: sync_offset %0d, inverted %0d", $signed(offset), inverted);
            errors++;
            return;
         end
         due = hits_due.pop_front();
         if (offset !== due.offset) begin
            $error("sync_offset: expected %0d, got %0d", $signed(due.offset), $signed(offset));
            errors++;
         end
         if (inverted !== due.inverted) begin
            $error("inverted: expected %0d, got %0d", due.inverted, inverted);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [DATA_W-1:0]           req_data_byte = '0;
   logic                        req_last_byte = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [POS_W-1:0]     rsp_sync_offset;
   logic                        rsp_inverted;
   logic                        csr_write = 1'b0;
   logic [IDX_W-1:0]            csr_index = '0;
   logic [WIN_W-1:0]            csr_wdata = '0;

   sync_hunt_board board;
   bit             pace_on = 1'b1;
   bit             frame_bits[$];
   bit             frame_open = 1'b0;
   int             items_sent = 0;
   int             rsp_hold = 0;
   int             quiet = 0;

   sync_word_bit_correlator_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sync_offset (rsp_sync_offset),
      .rsp_inverted    (rsp_inverted),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int idle_draw();
      if (!pace_on || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // result side: check accepted items, hold each new result for a drawn number of cycles
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_hit(rsp_sync_offset, rsp_inverted);
            rsp_hold = idle_draw();
         end else if (rsp_valid && rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_byte(input logic [DATA_W-1:0] data, input logic last);
      int gap;
      gap = idle_draw();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_byte(data, last);
   endtask

   // sender holds off until every owed result is back and the pipeline has emptied
   task automatic drain();
      req_valid <= 1'b0;
      while (board.hits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      board.write_reg(idx, value);
   endtask

   // word goes out MSB first starting at bit 'start', optionally complemented, with bit errors
   task automatic plant_word(input int start, input bit flip, input int bad_bits);
      int n;
      int k;
      n = board.span();
      for (k = 0; k < n; k++) begin
         if (start + k < frame_bits.size()) frame_bits[start + k] = board.pattern[n - 1 - k] ^ flip;
      end
      repeat (bad_bits) begin
         k = $urandom_range(0, n - 1);
         if (start + k < frame_bits.size()) frame_bits[start + k] = ~frame_bits[start + k];
      end
   endtask

   task automatic send_frame_bits(input bit close);
      int               b;
      int               i;
      int               nbytes;
      logic [DATA_W-1:0] data;
      nbytes = frame_bits.size() / DATA_W;
      for (b = 0; b < nbytes; b++) begin
         for (i = 0; i < DATA_W; i++) data[DATA_W - 1 - i] = frame_bits[DATA_W * b + i];
         push_byte(data, close && (b == nbytes - 1));
         items_sent++;
      end
   endtask

   task automatic random_frame();
      int n;
      int nbytes;
      int room;
      n = board.span();
      case ($urandom_range(0, 9))
         0:       nbytes = $urandom_range(1, 3);
         1:       nbytes = $urandom_range(8, 40);
         default: nbytes = (n + 7) / 8 + $urandom_range(1, 6);
      endcase
      frame_bits.delete();
      repeat (nbytes * DATA_W) frame_bits.push_back(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) < 7) begin
         room = nbytes * DATA_W - n;
         repeat ($urandom_range(1, 3)) begin
            plant_word((room > 0) ? $urandom_range(0, room) : 0, 1'($urandom_range(0, 1)),
                       $urandom_range(0, 3));
         end
      end
      send_frame_bits(1'b1);
      frame_open = 1'b0;
   endtask

   task automatic random_setup();
      logic [WIN_W-1:0] len_word;
      case ($urandom_range(0, 7))
         0:       write_csr(swbc_pkg::CSR_SYNC_PATTERN, '0);
         1:       write_csr(swbc_pkg::CSR_SYNC_PATTERN, '1);
         2:       ;
         default: write_csr(swbc_pkg::CSR_SYNC_PATTERN, {$urandom, $urandom});
      endcase
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 7))
            0:       len_word = WIN_W'(1);
            1:       len_word = WIN_W'(WIN_W);
            2:       len_word = '0;
            3:       len_word = WIN_W'($urandom_range(WIN_W + 1, 127));
            4:       len_word = {$urandom, $urandom};   // only the low 7 bits count
            5:       len_word = WIN_W'($urandom_range(1, WIN_W));
            default: len_word = WIN_W'($urandom_range(1, 16));
         endcase
         write_csr(swbc_pkg::CSR_SYNC_LENGTH, len_word);
      end
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // frame shorter than the word: nothing scored
      push_byte(8'h00, 1'b1);
      drain();
      // length 0 acts as 1; all-ones word, zero data gives a complement hit
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, '1);
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, '0);
      push_byte(8'h00, 1'b1);
      drain();
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, WIN_W'(8'hA5));
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, WIN_W'(8));
      push_byte(8'hA5, 1'b0);
      push_byte(8'h5A, 1'b1);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hFF, 1'b1);
      drain();
      // low bits 65 clamp to 64, upper bits ignored
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, 64'hFFFF_FFFF_FFFF_FFC1);
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, 64'h0123_4567_89AB_CDEF);
      push_byte(8'h01, 1'b0);
      push_byte(8'h23, 1'b0);
      push_byte(8'h45, 1'b0);
      push_byte(8'h67, 1'b0);
      push_byte(8'h89, 1'b0);
      push_byte(8'hAB, 1'b0);
      push_byte(8'hCD, 1'b0);
      push_byte(8'hEF, 1'b0);
      push_byte(8'h00, 1'b1);
      drain();
      // registers rewritten mid-frame: best so far kept, new length from the next bit
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, WIN_W'(16'h00FF));
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, WIN_W'(16));
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      drain();
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, WIN_W'(4));
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, WIN_W'(4'h5));
      push_byte(8'hF0, 1'b1);
      drain();
      // even length, equal distances: plain word wins the tie
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, WIN_W'(2));
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, WIN_W'(2'b01));
      push_byte(8'h00, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         drain();
         random_setup();
         pace_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 4)) random_frame();
         // sometimes leave the frame open across the next register writes
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               push_byte(8'($urandom), 1'b0);
               items_sent++;
            end
            frame_open = 1'b1;
         end
      end
      if (frame_open) push_byte(8'($urandom), 1'b1);

      // overlong frame: late match near the position limit, exact match past it is not scored
      drain();
      write_csr(swbc_pkg::CSR_SYNC_LENGTH, WIN_W'(WIN_W));
      write_csr(swbc_pkg::CSR_SYNC_PATTERN, {$urandom, $urandom});
      pace_on = 1'b0;
      frame_bits.delete();
      repeat ((swbc_pkg::MAX_FRAME_BYTES + 4) * DATA_W) begin
         frame_bits.push_back(1'($urandom_range(0, 1)));
      end
      plant_word(WIN_W, 1'b0, 2);
      plant_word(swbc_pkg::BIT_LIMIT - WIN_W - 1, 1'($urandom_range(0, 1)), 0);
      plant_word(swbc_pkg::BIT_LIMIT, 1'b0, 0);
      send_frame_bits(1'b1);
      drain();

      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/swbc_pkg.sv
hdl/swbc_front.sv
hdl/swbc_queue.sv
hdl/swbc_back.sv
hdl/sync_word_bit_correlator_top.sv
tb/tb_sync_word_bit_correlator_top.sv
